// File: design/pei_pkg.sv
package pei_pkg;

   // word format
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // configuration port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [2*WORD_BITS-1:0] prod_type;
   typedef logic [1:0]                    kind_type;
   typedef logic [2:0]                    reg_index_type;

   // request kinds
   localparam kind_type REQ_FORCE  = 2'd0;
   localparam kind_type REQ_STEP   = 2'd1;
   localparam kind_type REQ_SETPOS = 2'd2;
   localparam kind_type REQ_SETVEL = 2'd3;

   // register indexes
   localparam reg_index_type REG_INV_MASS = 3'd0;
   localparam reg_index_type REG_DAMPING  = 3'd1;
   localparam reg_index_type REG_STEP     = 3'd2;
   localparam reg_index_type REG_ACCEL_X  = 3'd3;
   localparam reg_index_type REG_ACCEL_Y  = 3'd4;
   localparam reg_index_type REG_ACCEL_Z  = 3'd5;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam word_type               INV_MASS_RESET  = word_type'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS:0]     DAMPING_RESET   = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [WORD_BITS-2:0]   TIME_STEP_RESET = (WORD_BITS-1)'(1092);

   typedef struct packed {
      word_type                inv_mass;
      logic [FRAC_BITS:0]      damping;
      logic [WORD_BITS-2:0]    time_step;
      word_type                accel_x;
      word_type                accel_y;
      word_type                accel_z;
   } cfg_type;

   typedef struct packed {
      kind_type  kind;
      logic      reject;
      word_type  vec_x;
      word_type  vec_y;
      word_type  vec_z;
   } cmd_type;

   typedef struct packed {
      word_type  pos_x;
      word_type  pos_y;
      word_type  pos_z;
      word_type  vel_x;
      word_type  vel_y;
      word_type  vel_z;
      logic      step_ok;
   } res_type;

   // saturating add of two words
   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] sum;
      sum = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
         return sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return sum[WORD_BITS-1:0];
   endfunction

   // product scaled down by the fraction bits, floor rounding, saturated
   function automatic word_type mul_q(input prod_type p);
      logic [WORD_BITS-FRAC_BITS:0] top;
      top = p[2*WORD_BITS-1:WORD_BITS+FRAC_BITS-1];
      if ((&top) || !(|top)) begin
         return p[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
      end
      return p[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX;
   endfunction

endpackage

// File: design/pei_req_if.sv
interface pei_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   pei_pkg::word_type      vec_x;
   pei_pkg::word_type      vec_y;
   pei_pkg::word_type      vec_z;

   modport source (output valid, output req_type, output vec_x, output vec_y, output vec_z,
                   input ready);
   modport sink (input valid, input req_type, input vec_x, input vec_y, input vec_z,
                 output ready);
endinterface

// File: design/pei_rsp_if.sv
interface pei_rsp_if;
   logic                   valid;
   logic                   ready;
   pei_pkg::word_type      pos_x;
   pei_pkg::word_type      pos_y;
   pei_pkg::word_type      pos_z;
   pei_pkg::word_type      vel_x;
   pei_pkg::word_type      vel_y;
   pei_pkg::word_type      vel_z;
   logic                   step_ok;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output vel_x, output vel_y, output vel_z, output step_ok,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input vel_x, input vel_y, input vel_z, input step_ok,
                 output ready);
endinterface

// File: design/particle_euler_integrator.sv
// flow: add-force, setter and rejected integrate beats go from queue via idle and done states
//   to the output register; an integrate beat first runs the six-step multiply sequence
//   (one multiplier per axis); the sequencer takes one item at a time and waits while rsp stalls;
//   a two-entry queue lets the request side run ahead of the sequencer
// reset: synchronous, active high; clears position, velocity and force sum to zero,
//   loads register reset values and empties the queue and the output register
module particle_euler_integrator (
   input  logic                                 clock,
   input  logic                                 reset,
   pei_req_if.sink                              req,
   pei_rsp_if.source                            rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pei_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [pei_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [pei_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import pei_pkg::*;

   cfg_type  cfg;
   cmd_type  push_cmd;
   cmd_type  pop_cmd;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;

   // request intake and registers
   pei_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   // command queue
   pei_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // state update and result beat
   pei_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

// File: design/pei_front.sv
module pei_front (
   input  logic                                 clock,
   input  logic                                 reset,
   pei_req_if.sink                              req,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pei_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [pei_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [pei_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output pei_pkg::cfg_type                     cfg,
   input  logic                                 q_full,
   output logic                                 q_push,
   output pei_pkg::cmd_type                     q_cmd
);
   import pei_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   reg_index_type  reg_index;
   logic           csr_write;

   assign reg_index = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_INV_MASS: cfg_in.inv_mass  = word_type'(pwdata);
            REG_DAMPING:  cfg_in.damping   = pwdata[FRAC_BITS:0];
            REG_STEP:     cfg_in.time_step = pwdata[WORD_BITS-2:0];
            REG_ACCEL_X:  cfg_in.accel_x   = word_type'(pwdata);
            REG_ACCEL_Y:  cfg_in.accel_y   = word_type'(pwdata);
            REG_ACCEL_Z:  cfg_in.accel_z   = word_type'(pwdata);
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_index)
         REG_INV_MASS: prdata = CSR_DATA_BITS'(cfg_ff.inv_mass);
         REG_DAMPING:  prdata = CSR_DATA_BITS'(cfg_ff.damping);
         REG_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.time_step);
         REG_ACCEL_X:  prdata = CSR_DATA_BITS'(cfg_ff.accel_x);
         REG_ACCEL_Y:  prdata = CSR_DATA_BITS'(cfg_ff.accel_y);
         REG_ACCEL_Z:  prdata = CSR_DATA_BITS'(cfg_ff.accel_z);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_mass  <= INV_MASS_RESET;
         cfg_ff.damping   <= DAMPING_RESET;
         cfg_ff.time_step <= TIME_STEP_RESET;
         cfg_ff.accel_x   <= '0;
         cfg_ff.accel_y   <= '0;
         cfg_ff.accel_z   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify request beats: integrate with non-positive inverse mass is rejected here
   assign req.ready    = !q_full;
   assign q_push       = req.valid && !q_full;
   assign q_cmd.kind   = req.req_type;
   assign q_cmd.reject = (req.req_type == REQ_STEP) &&
                         (cfg_ff.inv_mass[WORD_BITS-1] || !(|cfg_ff.inv_mass));
   assign q_cmd.vec_x  = req.vec_x;
   assign q_cmd.vec_y  = req.vec_y;
   assign q_cmd.vec_z  = req.vec_z;

endmodule

// File: design/pei_queue.sv
module pei_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pei_pkg::cmd_type   push_cmd,
   output logic               full,
   input  logic               pop,
   output pei_pkg::cmd_type   pop_cmd,
   output logic               empty
);
   import pei_pkg::*;

   cmd_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/pei_back.sv
module pei_back (
   input  logic               clock,
   input  logic               reset,
   input  pei_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  pei_pkg::cmd_type   q_cmd,
   output logic               q_pop,
   pei_rsp_if.source          rsp
);
   import pei_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // integrate sequence
   localparam logic [2:0] STEP_FORCE_MUL = 3'd0;
   localparam logic [2:0] STEP_VEL_MUL   = 3'd1;
   localparam logic [2:0] STEP_ACC_MUL   = 3'd2;
   localparam logic [2:0] STEP_VEL_SUM   = 3'd3;
   localparam logic [2:0] STEP_DAMP_MUL  = 3'd4;
   localparam logic [2:0] STEP_VEL_LOAD  = 3'd5;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   word_type    pos_ff [3];
   word_type    pos_in [3];
   word_type    vel_ff [3];
   word_type    vel_in [3];
   word_type    frc_ff [3];
   word_type    frc_in [3];
   word_type    tmp_ff [3];
   word_type    tmp_in [3];
   prod_type    prod_ff [3];
   prod_type    prod_in [3];
   word_type    opa [3];
   word_type    opb [3];
   word_type    acc [3];
   word_type    vec [3];
   logic        ok_ff, ok_in;
   logic        out_valid_ff, out_valid_in;
   res_type     out_ff, out_in;
   logic        out_free;
   word_type    dt_w;
   word_type    dmp_w;

   assign acc[0] = cfg.accel_x;
   assign acc[1] = cfg.accel_y;
   assign acc[2] = cfg.accel_z;
   assign vec[0] = q_cmd.vec_x;
   assign vec[1] = q_cmd.vec_y;
   assign vec[2] = q_cmd.vec_z;
   assign dt_w   = word_type'(cfg.time_step);
   assign dmp_w  = word_type'(cfg.damping);

   assign out_free = !out_valid_ff || rsp.ready;

   // one multiplier per axis lane, operands picked by sequence step
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i] = tmp_ff[i];
         opb[i] = dt_w;
         case (step_ff)
            STEP_FORCE_MUL: begin
               opa[i] = frc_ff[i];
               opb[i] = cfg.inv_mass;
            end
            STEP_VEL_MUL: begin
               opa[i] = vel_ff[i];
            end
            STEP_DAMP_MUL: begin
               opb[i] = dmp_w;
            end
            default: ;
         endcase
         prod_in[i] = opa[i] * opb[i];
      end
   end

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      frc_in       = frc_ff;
      tmp_in       = tmp_ff;
      ok_in        = ok_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      q_pop        = 1'b0;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ok_in    = 1'b1;
               state_in = ST_DONE;
               case (q_cmd.kind)
                  REQ_FORCE: begin
                     for (int i = 0; i < 3; i++) begin
                        frc_in[i] = sat_add(frc_ff[i], vec[i]);
                     end
                  end
                  REQ_STEP: begin
                     if (q_cmd.reject) begin
                        ok_in = 1'b0;
                     end else begin
                        state_in = ST_RUN;
                        step_in  = STEP_FORCE_MUL;
                     end
                  end
                  REQ_SETPOS: begin
                     pos_in = vec;
                  end
                  REQ_SETVEL: begin
                     vel_in = vec;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               case (step_ff)
                  STEP_VEL_MUL:  tmp_in[i] = sat_add(acc[i], mul_q(prod_ff[i]));
                  STEP_ACC_MUL:  pos_in[i] = sat_add(pos_ff[i], mul_q(prod_ff[i]));
                  STEP_VEL_SUM:  tmp_in[i] = sat_add(vel_ff[i], mul_q(prod_ff[i]));
                  STEP_VEL_LOAD: begin
                     vel_in[i] = mul_q(prod_ff[i]);
                     frc_in[i] = '0;
                  end
                  default: ;
               endcase
            end
            if (step_ff == STEP_VEL_LOAD) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_in.pos_x   = pos_ff[0];
               out_in.pos_y   = pos_ff[1];
               out_in.pos_z   = pos_ff[2];
               out_in.vel_x   = vel_ff[0];
               out_in.vel_y   = vel_ff[1];
               out_in.vel_z   = vel_ff[2];
               out_in.step_ok = ok_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FORCE_MUL;
         ok_ff        <= 1'b1;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ok_ff        <= ok_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         frc_ff       <= frc_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   // result beat
   assign rsp.valid   = out_valid_ff;
   assign rsp.pos_x   = out_ff.pos_x;
   assign rsp.pos_y   = out_ff.pos_y;
   assign rsp.pos_z   = out_ff.pos_z;
   assign rsp.vel_x   = out_ff.vel_x;
   assign rsp.vel_y   = out_ff.vel_y;
   assign rsp.vel_z   = out_ff.vel_z;
   assign rsp.step_ok = out_ff.step_ok;

endmodule
